### sv/crf_pkg.sv
// crf_pkg: shared types, constants and helpers of the chunk ring fifo
// used by crf_cell, chunk_ring_fifo_overflow_policy_top, chunk_fifo_checker and the tb
package crf_pkg;

    localparam int DEPTH_DEFAULT   = 16;
    localparam int MAX_CHUNK_BYTES = 8;
    localparam int DATA_W          = 64;
    localparam int LEN_W           = 4;
    localparam int BYTES_W         = 7;
    localparam int CNT_OUT_W       = 4;
    localparam int TOTAL_W         = 32;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [DATA_W-1:0] chunk_data;
        logic [LEN_W-1:0]  chunk_len;
    } t_in_item;

    typedef struct packed {
        logic                 accepted;
        logic                 dropped;
        logic [DATA_W-1:0]    out_data;
        logic [LEN_W-1:0]     out_len;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [BYTES_W-1:0]   bytes_held;
        logic                 is_full;
        logic                 is_empty;
        logic [TOTAL_W-1:0]   drop_total;
        logic [TOTAL_W-1:0]   enqueue_total;
        logic [TOTAL_W-1:0]   dequeue_total;
    } t_out_item;

    // one chunk held by a cell
    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_slot;

    // row-wide commands to every cell
    typedef struct packed {
        logic clear;
        logic shift;
        logic push;
    } t_cell_ctl;

    // what a cell sees of its neighbors
    typedef struct packed {
        t_slot up;
        logic  dn_valid;
        logic  has_dn;
    } t_nbr;

    // zero the bytes at and above len
    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] data,
                                                     input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] res;
        res = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (LEN_W'(b) < len) begin
                res[b*8 +: 8] = data[b*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

### sv/crf_stream_if.sv
// crf_stream_if: valid/ready channel carrying one item of type T
// payload types come from crf_pkg
interface crf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/crf_cell.sv
// crf_cell: one stage of the chunk row, holds one chunk and its valid bit
// depends on crf_pkg for the slot, control and neighbor structs
module crf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crf_pkg::t_cell_ctl i_ctl,
    input  crf_pkg::t_slot     i_new,
    input  crf_pkg::t_nbr      i_nbr,
    output crf_pkg::t_slot     o_slot
);

    logic                       r_valid;
    logic [crf_pkg::LEN_W-1:0]  r_len;
    logic [crf_pkg::DATA_W-1:0] r_data;
    crf_pkg::t_slot             w_base;
    crf_pkg::t_slot             n_slot;
    logic                       w_prev;

    always_comb begin
        // contents after an optional shift toward the head
        w_base = i_ctl.shift ? i_nbr.up : o_slot;
        w_prev = i_ctl.shift ? (r_valid || !i_nbr.has_dn) : (i_nbr.dn_valid || !i_nbr.has_dn);
        n_slot = w_base;
        if (i_ctl.push && !w_base.valid && w_prev) begin
            n_slot = i_new;
        end
        if (i_ctl.clear) begin
            n_slot.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_slot.len;
        r_data <= n_slot.data;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.len   = r_len;
    assign o_slot.data  = r_data;

endmodule

### sv/chunk_ring_fifo_overflow_policy_top.sv
// Chunk queue with a selectable overflow policy. Holds up to DEPTH-1 chunks of up to
// eight bytes in a row of cells; the oldest chunk sits in the head cell and a dequeue
// or an evict-head overflow shifts the whole row one cell toward the head in the same
// cycle, while an enqueue lands in the first free cell. An item is accepted whenever
// the result register is empty or being drained, and its result appears in that
// register on the next cycle, so one item per cycle is sustained while the output is
// ready. The overflow policy bit may be written at any time the queue is idle.
// No clearing pass is needed after reset.
// depends on crf_pkg, crf_stream_if and crf_cell
module chunk_ring_fifo_overflow_policy_top #(
    parameter int DEPTH = crf_pkg::DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    crf_stream_if.sink   i_in,
    crf_stream_if.source o_out,
    crf_stream_if.sink   i_cfg
);

    localparam int NCELL = DEPTH - 1;
    localparam int CNT_W = $clog2(DEPTH);

    logic                          r_evict_head;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic [crf_pkg::BYTES_W-1:0]   r_bytes;
    logic [crf_pkg::BYTES_W-1:0]   n_bytes;
    logic [crf_pkg::TOTAL_W-1:0]   r_drop_cnt;
    logic [crf_pkg::TOTAL_W-1:0]   n_drop_cnt;
    logic [crf_pkg::TOTAL_W-1:0]   r_enq_cnt;
    logic [crf_pkg::TOTAL_W-1:0]   n_enq_cnt;
    logic [crf_pkg::TOTAL_W-1:0]   r_deq_cnt;
    logic [crf_pkg::TOTAL_W-1:0]   n_deq_cnt;
    logic                          r_out_valid;
    crf_pkg::t_out_item            r_out;
    crf_pkg::t_out_item            n_out;

    logic                          w_in_fire;
    logic                          w_full;
    logic                          w_len_ok;
    logic [31:0]                   w_cnt_ext;
    crf_pkg::t_cell_ctl            w_ctl;
    crf_pkg::t_slot                w_new;
    crf_pkg::t_slot                w_slot [NCELL];
    logic [NCELL-1:0]              w_valid_vec;

    assign w_in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_full   = (r_count == CNT_W'(NCELL));
    assign w_len_ok = (i_in.data.chunk_len != '0)
                      && (i_in.data.chunk_len <= crf_pkg::LEN_W'(crf_pkg::MAX_CHUNK_BYTES));

    assign w_new.valid = 1'b1;
    assign w_new.len   = i_in.data.chunk_len;
    assign w_new.data  = crf_pkg::keep_bytes(i_in.data.chunk_data, i_in.data.chunk_len);

    always_comb begin
        w_ctl      = '0;
        n_count    = r_count;
        n_bytes    = r_bytes;
        n_drop_cnt = r_drop_cnt;
        n_enq_cnt  = r_enq_cnt;
        n_deq_cnt  = r_deq_cnt;
        n_out      = '0;
        if (w_in_fire) begin
            case (i_in.data.opcode)
                crf_pkg::OP_ENQUEUE: begin
                    if (w_len_ok) begin
                        if (w_full) begin
                            n_out.dropped = 1'b1;
                            n_drop_cnt    = r_drop_cnt + 1'b1;
                            if (r_evict_head) begin
                                w_ctl.shift    = 1'b1;
                                w_ctl.push     = 1'b1;
                                n_bytes        = r_bytes
                                                 - crf_pkg::BYTES_W'(w_slot[0].len)
                                                 + crf_pkg::BYTES_W'(i_in.data.chunk_len);
                                n_enq_cnt      = r_enq_cnt + 1'b1;
                                n_out.accepted = 1'b1;
                            end
                        end else begin
                            w_ctl.push     = 1'b1;
                            n_count        = r_count + 1'b1;
                            n_bytes        = r_bytes + crf_pkg::BYTES_W'(i_in.data.chunk_len);
                            n_enq_cnt      = r_enq_cnt + 1'b1;
                            n_out.accepted = 1'b1;
                        end
                    end
                end
                crf_pkg::OP_DEQUEUE: begin
                    if (r_count != '0) begin
                        w_ctl.shift    = 1'b1;
                        n_count        = r_count - 1'b1;
                        n_bytes        = r_bytes - crf_pkg::BYTES_W'(w_slot[0].len);
                        n_deq_cnt      = r_deq_cnt + 1'b1;
                        n_out.accepted = 1'b1;
                        n_out.out_data = w_slot[0].data;
                        n_out.out_len  = w_slot[0].len;
                    end
                end
                crf_pkg::OP_CLEAR: begin
                    w_ctl.clear = 1'b1;
                    n_count     = '0;
                    n_bytes     = '0;
                end
                default: begin
                end
            endcase
        end
        w_cnt_ext           = 32'(n_count);
        n_out.entry_count   = w_cnt_ext[crf_pkg::CNT_OUT_W-1:0];
        n_out.bytes_held    = n_bytes;
        n_out.is_full       = (n_count == CNT_W'(NCELL));
        n_out.is_empty      = (n_count == '0);
        n_out.drop_total    = n_drop_cnt;
        n_out.enqueue_total = n_enq_cnt;
        n_out.dequeue_total = n_deq_cnt;
    end

    // row of chunk cells, cell 0 holds the oldest chunk
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        crf_pkg::t_nbr w_nbr;
        if (g == NCELL - 1) begin : g_top
            assign w_nbr.up = '0;
        end else begin : g_mid
            assign w_nbr.up = w_slot[g+1];
        end
        if (g == 0) begin : g_head
            assign w_nbr.dn_valid = 1'b1;
            assign w_nbr.has_dn   = 1'b0;
        end else begin : g_body
            assign w_nbr.dn_valid = w_slot[g-1].valid;
            assign w_nbr.has_dn   = 1'b1;
        end
        crf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_new   (w_new),
            .i_nbr   (w_nbr),
            .o_slot  (w_slot[g])
        );
        assign w_valid_vec[g] = w_slot[g].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evict_head <= 1'b0;
            r_count      <= '0;
            r_bytes      <= '0;
            r_drop_cnt   <= '0;
            r_enq_cnt    <= '0;
            r_deq_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_evict_head <= i_cfg.data;
            end
            r_count    <= n_count;
            r_bytes    <= n_bytes;
            r_drop_cnt <= n_drop_cnt;
            r_enq_cnt  <= n_enq_cnt;
            r_deq_cnt  <= n_deq_cnt;
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out <= n_out;
        end
    end

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_count))
        else $error("chunk count differs from occupied cells");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec + NCELL'(1)) & w_valid_vec) == '0)
        else $error("gap in occupied cells");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_bytes == '0))
        else $error("bytes held while empty");

    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_out_valid)
        else $error("item accepted without result");

endmodule

### verif/chunk_fifo_checker.sv
`timescale 1ns / 1ps
// chunk_fifo_checker: keeps its own copy of the chunk ring, predicts the result of every
// accepted item and compares it field by field with the items leaving the block
// depends on crf_pkg and crf_stream_if
module chunk_fifo_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    crf_stream_if i_in_mon,
    crf_stream_if i_out_mon,
    crf_stream_if i_cfg_mon,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int RING = crf_pkg::DEPTH_DEFAULT;

    logic [crf_pkg::DATA_W-1:0]  ring_data [RING];
    logic [crf_pkg::LEN_W-1:0]   ring_len [RING];
    int                          wr_ptr;
    int                          rd_ptr;
    logic [crf_pkg::BYTES_W-1:0] byte_sum;
    logic [crf_pkg::TOTAL_W-1:0] drops;
    logic [crf_pkg::TOTAL_W-1:0] enqueues;
    logic [crf_pkg::TOTAL_W-1:0] dequeues;
    logic                        evict_head_q;
    crf_pkg::t_out_item          expected_q[$];
    int                          result_idx;

    function automatic crf_pkg::t_out_item apply_chunk_op(input crf_pkg::t_in_item it);
        crf_pkg::t_out_item         res;
        int                         nxt;
        logic                       take;
        logic [crf_pkg::DATA_W-1:0] mask;
        res = '0;
        case (it.opcode)
            crf_pkg::OP_ENQUEUE: begin
                if (it.chunk_len != 0 && it.chunk_len <= crf_pkg::MAX_CHUNK_BYTES) begin
                    nxt  = (wr_ptr + 1) % RING;
                    take = 1'b1;
                    if (nxt == rd_ptr) begin
                        res.dropped = 1'b1;
                        drops++;
                        if (evict_head_q) begin
                            byte_sum = byte_sum - crf_pkg::BYTES_W'(ring_len[rd_ptr]);
                            rd_ptr   = (rd_ptr + 1) % RING;
                        end else begin
                            take = 1'b0;
                        end
                    end
                    if (take) begin
                        if (it.chunk_len >= 8) begin
                            mask = '1;
                        end else begin
                            mask = (64'd1 << (8 * it.chunk_len)) - 64'd1;
                        end
                        ring_data[wr_ptr] = it.chunk_data & mask;
                        ring_len[wr_ptr]  = it.chunk_len;
                        wr_ptr            = nxt;
                        enqueues++;
                        byte_sum     = byte_sum + crf_pkg::BYTES_W'(it.chunk_len);
                        res.accepted = 1'b1;
                    end
                end
            end
            crf_pkg::OP_DEQUEUE: begin
                if (rd_ptr != wr_ptr) begin
                    res.out_data = ring_data[rd_ptr];
                    res.out_len  = ring_len[rd_ptr];
                    rd_ptr       = (rd_ptr + 1) % RING;
                    dequeues++;
                    byte_sum     = byte_sum - crf_pkg::BYTES_W'(res.out_len);
                    res.accepted = 1'b1;
                end
            end
            crf_pkg::OP_CLEAR: begin
                wr_ptr   = 0;
                rd_ptr   = 0;
                byte_sum = '0;
            end
            default: begin
            end
        endcase
        res.entry_count   = crf_pkg::CNT_OUT_W'((wr_ptr + RING - rd_ptr) % RING);
        res.bytes_held    = byte_sum;
        res.is_full       = ((wr_ptr + 1) % RING) == rd_ptr;
        res.is_empty      = wr_ptr == rd_ptr;
        res.drop_total    = drops;
        res.enqueue_total = enqueues;
        res.dequeue_total = dequeues;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            if (o_fail_count < 10) begin
                $display("result %0d %s: expected %0h actual %0h", result_idx, field,
                         exp_v, act_v);
            end
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        crf_pkg::t_out_item exp_res;
        crf_pkg::t_out_item got;
        if (!i_rst_n) begin
            wr_ptr       = 0;
            rd_ptr       = 0;
            byte_sum     = '0;
            drops        = '0;
            enqueues     = '0;
            dequeues     = '0;
            evict_head_q = 1'b0;
            expected_q.delete();
            result_idx   = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                evict_head_q = i_cfg_mon.data;
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("result %0d arrived with nothing expected", result_idx);
                    end
                    o_fail_count++;
                end else begin
                    exp_res = expected_q.pop_front();
                    check_field("accepted", exp_res.accepted, got.accepted);
                    check_field("dropped", exp_res.dropped, got.dropped);
                    check_field("out_data", exp_res.out_data, got.out_data);
                    check_field("out_len", exp_res.out_len, got.out_len);
                    check_field("entry_count", exp_res.entry_count, got.entry_count);
                    check_field("bytes_held", exp_res.bytes_held, got.bytes_held);
                    check_field("is_full", exp_res.is_full, got.is_full);
                    check_field("is_empty", exp_res.is_empty, got.is_empty);
                    check_field("drop_total", exp_res.drop_total, got.drop_total);
                    check_field("enqueue_total", exp_res.enqueue_total, got.enqueue_total);
                    check_field("dequeue_total", exp_res.dequeue_total, got.dequeue_total);
                end
                result_idx++;
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_q.push_back(apply_chunk_op(i_in_mon.data));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

### verif/chunk_ring_fifo_overflow_policy_top_tb.sv
`timescale 1ns / 1ps
// chunk_ring_fifo_overflow_policy_top_tb: drives directed and random chunk queue items
// under both overflow policies and several idle patterns, and gives the verdict
// depends on crf_pkg, crf_stream_if, chunk_fifo_checker and the block itself
module chunk_ring_fifo_overflow_policy_top_tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SEG_ITEMS   = 110;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sender_idle_pct;
    int   stall_pct;

    crf_stream_if #(.T(crf_pkg::t_in_item))  in_if ();
    crf_stream_if #(.T(crf_pkg::t_out_item)) out_if ();
    crf_stream_if #(.T(logic))               cfg_if ();

    chunk_ring_fifo_overflow_policy_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    chunk_fifo_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_if),
        .i_out_mon    (out_if),
        .i_cfg_mon    (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[chunk_ring_fifo_overflow_policy_top] ERROR");
        $finish;
    end

    // result side backpressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input crf_pkg::t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic write_policy(input logic evict_head);
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= evict_head;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_segment(input int n_items);
        crf_pkg::t_in_item it;
        int                roll;
        int                burst_left;
        bit                fill_mode;
        burst_left = 0;
        fill_mode  = 1'b0;
        for (int k = 0; k < n_items; k++) begin
            if (burst_left == 0) begin
                fill_mode  = 1'($urandom_range(1));
                burst_left = $urandom_range(40, 15);
            end
            burst_left--;
            roll          = $urandom_range(99);
            it.chunk_data = {$urandom, $urandom};
            it.chunk_len  = crf_pkg::LEN_W'($urandom_range(crf_pkg::MAX_CHUNK_BYTES, 1));
            if (roll < 2) begin
                it.opcode = crf_pkg::OP_CLEAR;
            end else if (roll < 6) begin
                it.opcode    = OP_UNUSED;
                it.chunk_len = crf_pkg::LEN_W'($urandom);
            end else if (roll < 12) begin
                it.opcode = crf_pkg::OP_ENQUEUE;
                if ($urandom_range(2) == 0) begin
                    it.chunk_len = '0;
                end else begin
                    it.chunk_len = crf_pkg::LEN_W'(
                        $urandom_range(15, crf_pkg::MAX_CHUNK_BYTES + 1));
                end
            end else if (roll < (fill_mode ? 85 : 42)) begin
                it.opcode = crf_pkg::OP_ENQUEUE;
            end else begin
                it.opcode = crf_pkg::OP_DEQUEUE;
            end
            send_item(it);
        end
    endtask

    initial begin
        int sender_by_phase [4];
        int stall_by_phase [4];
        sender_by_phase = '{0, 62, 0, 37};
        stall_by_phase  = '{0, 0, 62, 37};
        sender_idle_pct = 0;
        stall_pct       = 0;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reject policy first
        write_policy(1'b0);
        send_item('{crf_pkg::OP_DEQUEUE, 64'h0, 4'd0});
        send_item('{crf_pkg::OP_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0});
        send_item('{crf_pkg::OP_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9});
        send_item('{crf_pkg::OP_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15});
        send_item('{OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15});
        send_item('{crf_pkg::OP_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1});
        send_item('{crf_pkg::OP_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8});
        send_item('{crf_pkg::OP_DEQUEUE, 64'h0, 4'd0});
        // fill up to the spare slot, then overflow
        for (int k = 0; k < 14; k++) begin
            send_item('{crf_pkg::OP_ENQUEUE, {$urandom, $urandom},
                        crf_pkg::LEN_W'($urandom_range(crf_pkg::MAX_CHUNK_BYTES, 1))});
        end
        send_item('{crf_pkg::OP_ENQUEUE, 64'h0123_4567_89AB_CDEF, 4'd8});
        write_policy(1'b1);
        send_item('{crf_pkg::OP_ENQUEUE, 64'h0, 4'd8});
        send_item('{crf_pkg::OP_CLEAR, 64'h0, 4'd0});

        for (int seg = 0; seg < 8; seg++) begin
            write_policy(seg[0]);
            sender_idle_pct = sender_by_phase[seg / 2];
            stall_pct       = stall_by_phase[seg / 2];
            run_segment(SEG_ITEMS);
        end

        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[chunk_ring_fifo_overflow_policy_top] OK");
        end else begin
            $display("[chunk_ring_fifo_overflow_policy_top] ERROR");
        end
        $finish;
    end

endmodule
